[sv/mst_pkg.sv]
// Package for the Prim minimum spanning tree block: field widths, codes and
// the packed types used by the modules; the interfaces take the widths. No dependencies.
`default_nettype none
package mst_pkg;

  localparam int VIDX_W       = 4;
  localparam int WGT_W        = 16;
  localparam int CFG_W        = 5;
  localparam int VFIELD_LIMIT = 16;
  localparam int MIN_VERTICES = 2;
  localparam int MAX_TREE     = VFIELD_LIMIT - 1;
  localparam int TIDX_W       = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef struct packed {
    logic [VIDX_W-1:0] src;
    logic [VIDX_W-1:0] tgt;
    logic [WGT_W-1:0]  wgt;
  } entry_t;

  typedef struct packed {
    logic              operation;
    logic [VIDX_W-1:0] edge_source;
    logic [VIDX_W-1:0] edge_target;
    logic [WGT_W-1:0]  edge_weight;
  } item_t;

  typedef struct packed {
    logic [VIDX_W-1:0] tree_source;
    logic [VIDX_W-1:0] tree_target;
    logic [WGT_W-1:0]  tree_weight;
    logic              last;
    logic              error;
  } result_t;

endpackage
`default_nettype wire

[sv/mst_if.sv]
// Valid/ready channel interfaces for the edge input and the tree result.
// Depends on mst_pkg for the field widths.
`default_nettype none
interface mst_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [mst_pkg::VIDX_W-1:0] edge_source;
  logic [mst_pkg::VIDX_W-1:0] edge_target;
  logic [mst_pkg::WGT_W-1:0]  edge_weight;

  modport source(output valid, operation, edge_source, edge_target, edge_weight,
                 input ready);
  modport sink(input valid, operation, edge_source, edge_target, edge_weight,
               output ready);
endinterface

interface mst_out_if;
  logic                      valid;
  logic                      ready;
  logic [mst_pkg::VIDX_W-1:0] tree_source;
  logic [mst_pkg::VIDX_W-1:0] tree_target;
  logic [mst_pkg::WGT_W-1:0]  tree_weight;
  logic                      last;
  logic                      error;

  modport source(output valid, tree_source, tree_target, tree_weight, last, error,
                 input ready);
  modport sink(input valid, tree_source, tree_target, tree_weight, last, error,
               output ready);
endinterface
`default_nettype wire

[sv/mst_edge_ram.sv]
// Edge table memory: one write port, one read port with registered data.
// Depends on mst_pkg for the entry type.
`default_nettype none
module mst_edge_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mst_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output mst_pkg::entry_t      rdata
);

  mst_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/mst_prim_core.sv]
// Load and scan sequencer: appends edges to the table, runs Prim's selection
// one table pass per tree edge, buffers the chosen edges and hands them out.
// Depends on mst_pkg and drives the ports of mst_edge_ram.
`default_nettype none
module mst_prim_core #(
  parameter int MAX_EDGES = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_fire,
  input  wire mst_pkg::item_t            item,
  input  wire logic [mst_pkg::CFG_W-1:0] n_eff,
  output logic                           busy,
  output logic                           ram_we,
  output logic [AW-1:0]                  ram_waddr,
  output mst_pkg::entry_t                ram_wdata,
  output logic                           ram_re,
  output logic [AW-1:0]                  ram_raddr,
  input  wire mst_pkg::entry_t           ram_rdata,
  output logic                           emit_valid,
  input  wire logic                      emit_ready,
  output mst_pkg::result_t               emit_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_ERR  = 3'd3;

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               rd_idx_r, rd_idx_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [mst_pkg::TIDX_W-1:0]  k_r, k_nxt;
  logic [mst_pkg::TIDX_W-1:0]  klast_r, klast_nxt;
  logic [mst_pkg::TIDX_W-1:0]  eidx_r, eidx_nxt;
  logic [mst_pkg::CFG_W-1:0]   n_r, n_nxt;
  logic [mst_pkg::VFIELD_LIMIT-1:0] mask_r, mask_nxt;
  logic                        found_r, found_nxt;
  mst_pkg::entry_t             best_r, best_nxt;
  mst_pkg::entry_t             chosen_r [mst_pkg::MAX_TREE];
  logic                        chosen_we;
  logic                        usable, cand_ok, better;
  logic [mst_pkg::CFG_W-1:0]   klast_full;

  assign usable = ({1'b0, ram_rdata.src} < n_r) && ({1'b0, ram_rdata.tgt} < n_r)
                  && (ram_rdata.src != ram_rdata.tgt);
  assign cand_ok = usable && ((k_r == '0) ||
                   (mask_r[ram_rdata.src] && !mask_r[ram_rdata.tgt]));
  assign better = !found_r || (ram_rdata.wgt < best_r.wgt);
  assign klast_full = n_eff - mst_pkg::CFG_W'(mst_pkg::MIN_VERTICES);

  assign busy      = (state_r != S_IDLE);
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = '{src: item.edge_source, tgt: item.edge_target, wgt: item.edge_weight};
  assign ram_raddr = rd_idx_r[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    rd_vld_nxt = 1'b0;
    k_nxt      = k_r;
    klast_nxt  = klast_r;
    eidx_nxt   = eidx_r;
    n_nxt      = n_r;
    mask_nxt   = mask_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    chosen_we  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    emit_valid = 1'b0;
    emit_data  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && item.operation == mst_pkg::OP_LOAD) begin
          if (count_r < CW'(MAX_EDGES)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (in_fire) begin
          n_nxt      = n_eff;
          klast_nxt  = klast_full[mst_pkg::TIDX_W-1:0];
          cnt_nxt    = count_r;
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          mask_nxt   = '0;
          rd_idx_nxt = '0;
          k_nxt      = '0;
          found_nxt  = 1'b0;
          state_nxt  = (ovf_r || count_r == '0) ? S_ERR : S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re = (rd_idx_r < cnt_r);
        rd_vld_nxt = ram_re;
        if (ram_re) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (rd_vld_r && cand_ok && better) begin
          best_nxt  = ram_rdata;
          found_nxt = 1'b1;
        end
        if (!ram_re && !rd_vld_r) begin
          if (!found_r) begin
            state_nxt = S_ERR;
          end else begin
            chosen_we = 1'b1;
            mask_nxt  = mask_r | (mst_pkg::VFIELD_LIMIT'(1) << best_r.src)
                               | (mst_pkg::VFIELD_LIMIT'(1) << best_r.tgt);
            if (k_r == klast_r) begin
              eidx_nxt  = '0;
              state_nxt = S_EMIT;
            end else begin
              k_nxt      = k_r + 1'b1;
              rd_idx_nxt = '0;
              found_nxt  = 1'b0;
            end
          end
        end
      end
      S_EMIT: begin
        emit_valid = 1'b1;
        emit_data  = '{tree_source: chosen_r[eidx_r].src, tree_target: chosen_r[eidx_r].tgt,
                       tree_weight: chosen_r[eidx_r].wgt, last: (eidx_r == klast_r),
                       error: 1'b0};
        if (emit_ready) begin
          if (eidx_r == klast_r) begin
            state_nxt = S_IDLE;
          end else begin
            eidx_nxt = eidx_r + 1'b1;
          end
        end
      end
      S_ERR: begin
        emit_valid = 1'b1;
        emit_data  = '{tree_source: '0, tree_target: '0, tree_weight: '0,
                       last: 1'b1, error: 1'b1};
        if (emit_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      rd_vld_r <= 1'b0;
      mask_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      rd_vld_r <= rd_vld_nxt;
      mask_r   <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    rd_idx_r <= rd_idx_nxt;
    k_r      <= k_nxt;
    klast_r  <= klast_nxt;
    eidx_r   <= eidx_nxt;
    n_r      <= n_nxt;
    found_r  <= found_nxt;
    best_r   <= best_nxt;
    if (chosen_we) begin
      chosen_r[k_r] <= best_r;
    end
  end

endmodule
`default_nettype wire

[sv/minimum_spanning_tree_prim.sv]
// Top level of the Prim minimum spanning tree block: configuration register,
// result output register and the assembly of mst_prim_core and mst_edge_ram.
// Depends on mst_pkg and the channel interfaces in mst_if.sv.
`default_nettype none

// Edge loads are taken one beat per cycle, back to back, into the edge table
// memory. A run command reads the whole table once per tree edge through the
// memory's single read port, one entry per cycle. The first result beat
// passes through the emit state and the output register. Further result
// beats follow one per cycle as the output side takes them.
// A run on an empty or overflowed table skips the scan and shows its single
// error beat through the error state and the output register. No input beat
// is accepted while a run is in progress. A load into a full table is dropped
// and makes the next run report a single error beat.
module minimum_spanning_tree_prim #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [mst_pkg::CFG_W-1:0] cfg_wdata,
  mst_in_if.sink                         in_ch,
  mst_out_if.source                      out_ch
);

  localparam int AW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int VLIM = (MAX_VERTICES < mst_pkg::VFIELD_LIMIT) ? MAX_VERTICES
                                                               : mst_pkg::VFIELD_LIMIT;

  logic [mst_pkg::CFG_W-1:0] vcount_r, vcount_nxt;
  logic [mst_pkg::CFG_W-1:0] n_eff;
  logic                      busy, in_fire;
  mst_pkg::item_t            item;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  mst_pkg::entry_t           ram_wdata, ram_rdata;
  logic                      emit_valid, emit_ready, emit_fire;
  mst_pkg::result_t          emit_data;
  logic                      out_valid_r, out_valid_nxt;
  mst_pkg::result_t          out_data_r;

  assign vcount_nxt = cfg_we ? cfg_wdata : vcount_r;
  assign n_eff = (vcount_r < mst_pkg::CFG_W'(mst_pkg::MIN_VERTICES))
                 ? mst_pkg::CFG_W'(mst_pkg::MIN_VERTICES)
                 : ((vcount_r > mst_pkg::CFG_W'(VLIM)) ? mst_pkg::CFG_W'(VLIM) : vcount_r);

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && !busy;
  assign item = '{operation: in_ch.operation, edge_source: in_ch.edge_source,
                  edge_target: in_ch.edge_target, edge_weight: in_ch.edge_weight};

  assign emit_ready    = !out_valid_r || out_ch.ready;
  assign emit_fire     = emit_valid && emit_ready;
  assign out_valid_nxt = emit_fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= mst_pkg::CFG_W'(mst_pkg::MIN_VERTICES);
      out_valid_r <= 1'b0;
    end else begin
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= emit_data;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tree_source = out_data_r.tree_source;
  assign out_ch.tree_target = out_data_r.tree_target;
  assign out_ch.tree_weight = out_data_r.tree_weight;
  assign out_ch.last        = out_data_r.last;
  assign out_ch.error       = out_data_r.error;

  mst_edge_ram #(
    .DEPTH(MAX_EDGES),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mst_prim_core #(
    .MAX_EDGES(MAX_EDGES),
    .AW       (AW),
    .CW       (CW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .item      (item),
    .n_eff     (n_eff),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .emit_valid(emit_valid),
    .emit_ready(emit_ready),
    .emit_data (emit_data)
  );

  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.operation == mst_pkg::OP_RUN) |=> !in_ch.ready)
    else $error("run beat accepted but block did not go busy");

  a_load_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.operation == mst_pkg::OP_LOAD) |=> in_ch.ready)
    else $error("load beat stalled the input");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error) |-> (out_ch.last && out_ch.tree_weight == '0 &&
                                        out_ch.tree_source == '0 && out_ch.tree_target == '0))
    else $error("error beat is not a zero final beat");

  a_no_loop_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.error) |-> (out_ch.tree_source != out_ch.tree_target))
    else $error("tree edge joins a vertex to itself");

endmodule
`default_nettype wire
